// ----- rtl/cmf_pkg.sv -----
package cmf_pkg;

    // Widths fixed by the item formats
    localparam int DATA_W  = 16;
    localparam int SUM_W   = 36;
    localparam int INDEX_W = 5;
    localparam int TAPS    = 9;
    localparam int KIDX_W  = 4;

    // Item kinds carried in the mode field
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_PIXEL = 1'b1;

    // Classified item handed from the front to the back
    typedef struct packed {
        logic                     is_pixel;
        logic                     is_first;
        logic                     is_last;
        logic                     in_pool;
        logic [INDEX_W-1:0]       base_idx;
        logic                     last_block;
        logic [7:0]               pool_col;
        logic [TAPS*DATA_W-1:0]   window;
    } cmf_item_t;

endpackage

// ----- rtl/cmf_front.sv -----
module cmf_front #(
    parameter int IMAGE_SIZE = 11,
    parameter int POOL_OUT   = 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  logic                 in_mode,
    input  logic signed [15:0]   in_pixel,
    input  logic                 out_ready,
    output logic                 out_valid,
    output cmf_pkg::cmf_item_t   out_item
);

    localparam int POS_W   = $clog2(IMAGE_SIZE);
    localparam int PC_W    = (POOL_OUT > 1) ? $clog2(POOL_OUT) : 1;
    localparam int INDEX_W = cmf_pkg::INDEX_W;

    logic [POS_W-1:0] row_reg, col_reg;
    // Sub-block counters track position modulo three inside the pool grid
    logic [1:0]       ysub_reg, xsub_reg;
    logic [PC_W:0]    py_reg, pxc_reg;
    logic [15:0]      line0 [IMAGE_SIZE];
    logic [15:0]      line1 [IMAGE_SIZE];
    logic [15:0]      win_reg [9];
    logic             fire;
    logic [15:0]      above2, above1;

    assign fire   = in_valid && in_mode == cmf_pkg::MODE_PIXEL;
    assign above2 = line0[col_reg];
    assign above1 = line1[col_reg];

    // Line buffers and window
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) win_reg[i] <= '0;
            for (int i = 0; i < IMAGE_SIZE; i++) begin
                line0[i] <= '0;
                line1[i] <= '0;
            end
        end else if (fire) begin
            line0[col_reg] <= above1;
            line1[col_reg] <= in_pixel;
            for (int m = 0; m < 3; m++) begin
                win_reg[m*3]   <= win_reg[m*3+1];
                win_reg[m*3+1] <= win_reg[m*3+2];
            end
            win_reg[2] <= above2;
            win_reg[5] <= above1;
            win_reg[8] <= in_pixel;
        end
    end

    // Position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            ysub_reg <= '0;
            xsub_reg <= '0;
            py_reg   <= '0;
            pxc_reg  <= '0;
        end else if (fire) begin
            if (32'(col_reg) == IMAGE_SIZE - 1) begin
                col_reg  <= '0;
                xsub_reg <= '0;
                pxc_reg  <= '0;
                if (32'(row_reg) == IMAGE_SIZE - 1) begin
                    row_reg  <= '0;
                    ysub_reg <= '0;
                    py_reg   <= '0;
                end else begin
                    row_reg <= row_reg + 1'b1;
                    if (row_reg >= POS_W'(2)) begin
                        if (ysub_reg == 2'd2) begin
                            ysub_reg <= '0;
                            if (32'(py_reg) < POOL_OUT) py_reg <= py_reg + 1'b1;
                        end else begin
                            ysub_reg <= ysub_reg + 1'b1;
                        end
                    end
                end
            end else begin
                col_reg <= col_reg + 1'b1;
                if (col_reg >= POS_W'(2)) begin
                    if (xsub_reg == 2'd2) begin
                        xsub_reg <= '0;
                        if (32'(pxc_reg) < POOL_OUT) pxc_reg <= pxc_reg + 1'b1;
                    end else begin
                        xsub_reg <= xsub_reg + 1'b1;
                    end
                end
            end
        end
    end

    // Classified item register; holds while the queue is full
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (out_ready || !out_valid) begin
            out_valid <= in_valid;
            if (in_valid) begin
                out_item.is_pixel <= fire;
                out_item.in_pool  <= row_reg >= POS_W'(2) && col_reg >= POS_W'(2)
                                     && 32'(py_reg) < POOL_OUT && 32'(pxc_reg) < POOL_OUT;
                out_item.is_first <= ysub_reg == 2'd0 && xsub_reg == 2'd0;
                out_item.is_last  <= ysub_reg == 2'd2 && xsub_reg == 2'd2;
                out_item.base_idx <= INDEX_W'(32'(py_reg) * POOL_OUT + 32'(pxc_reg));
                out_item.last_block <= 32'(py_reg) == POOL_OUT - 1
                                       && 32'(pxc_reg) == POOL_OUT - 1;
                out_item.pool_col <= 8'(pxc_reg);
                for (int k = 0; k < 9; k++) begin
                    if (k % 3 == 2)
                        out_item.window[k*16 +: 16] <= (k == 2) ? above2 :
                                                       (k == 5) ? above1 : in_pixel;
                    else
                        out_item.window[k*16 +: 16] <= win_reg[k+1];
                end
            end
        end
    end

endmodule

// ----- rtl/cmf_back.sv -----
module cmf_back #(
    parameter int POOL_OUT     = 3,
    parameter int FILTER_COUNT = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load_en,
    input  logic               load_filter,
    input  logic [3:0]         load_index,
    input  logic [15:0]        load_value,
    input  logic               in_valid,
    input  cmf_pkg::cmf_item_t in_item,
    output logic               in_ready,
    output logic               m_valid,
    output logic [35:0]        m_value,
    output logic [4:0]         m_index,
    output logic               m_done,
    input  logic               m_ready
);

    localparam int FW = (FILTER_COUNT > 1) ? $clog2(FILTER_COUNT) : 1;

    logic signed [15:0] coef_reg [FILTER_COUNT*9];
    logic signed [35:0] pmax_reg [FILTER_COUNT*POOL_OUT];
    // Product stage
    logic signed [31:0] prod_reg [FILTER_COUNT][9];
    logic               s1_valid, s1_first, s1_last, s1_pool, s1_lastblk;
    logic [4:0]         s1_base;
    logic [7:0]         s1_col;
    // Sum stage
    logic signed [35:0] sum_w [FILTER_COUNT];
    // Output buffer holding one result per filter
    logic [35:0]        ob_val [FILTER_COUNT];
    logic [4:0]         ob_idx [FILTER_COUNT];
    logic               ob_done [FILTER_COUNT];
    logic [FW:0]        ob_cnt, ob_ptr;
    logic [FW:0]        ob_cnt_next, ob_ptr_next;
    logic               adv;

    // Stage one can move only when the output buffer is empty or draining last
    assign adv      = ob_cnt == '0 || (ob_cnt == (FW+1)'(1) && m_ready);
    assign in_ready = adv;

    // Coefficient store; loads are in order with pixels since they come through the front
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FILTER_COUNT*9; i++) coef_reg[i] <= '0;
        end else if (load_en && load_index < 4'd9 && 32'(load_filter) < FILTER_COUNT) begin
            coef_reg[32'(load_filter)*9 + 32'(load_index)] <= load_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid <= 1'b0;
        end else if (adv) begin
            s1_valid <= in_valid && in_item.is_pixel && in_item.in_pool;
            s1_first <= in_item.is_first;
            s1_last  <= in_item.is_last;
            s1_lastblk <= in_item.last_block;
            s1_base  <= in_item.base_idx;
            s1_col   <= in_item.pool_col;
            for (int f = 0; f < FILTER_COUNT; f++)
                for (int k = 0; k < 9; k++)
                    prod_reg[f][k] <= $signed(in_item.window[k*16 +: 16]) * coef_reg[f*9+k];
        end
    end

    always_comb begin
        for (int f = 0; f < FILTER_COUNT; f++) begin
            sum_w[f] = '0;
            for (int k = 0; k < 9; k++) sum_w[f] = sum_w[f] + 36'(prod_reg[f][k]);
        end
    end

    // Buffer occupancy: a completed window refills it, otherwise a transfer drains it
    always_comb begin
        ob_cnt_next = ob_cnt;
        ob_ptr_next = ob_ptr;
        if (adv && s1_valid && s1_last) begin
            ob_cnt_next = (FW+1)'(FILTER_COUNT);
            ob_ptr_next = '0;
        end else if (m_valid && m_ready) begin
            ob_cnt_next = ob_cnt - 1'b1;
            ob_ptr_next = ob_ptr + 1'b1;
        end
    end

    // Pool update and result buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < FILTER_COUNT*POOL_OUT; i++) pmax_reg[i] <= '0;
            ob_cnt <= '0;
            ob_ptr <= '0;
        end else begin
            ob_cnt <= ob_cnt_next;
            ob_ptr <= ob_ptr_next;
            if (adv && s1_valid) begin
                for (int f = 0; f < FILTER_COUNT; f++) begin
                    logic signed [35:0] nm;
                    nm = pmax_reg[f*POOL_OUT + 32'(s1_col)];
                    if (s1_first || sum_w[f] > nm) nm = sum_w[f];
                    pmax_reg[f*POOL_OUT + 32'(s1_col)] <= nm;
                    ob_val[f]  <= nm;
                    ob_idx[f]  <= 5'(f*POOL_OUT*POOL_OUT + 32'(s1_base));
                    ob_done[f] <= s1_lastblk && f == FILTER_COUNT-1;
                end
            end
        end
    end

    assign m_valid = ob_cnt != '0;
    assign m_value = ob_val[ob_ptr[FW-1:0] & FW'(FILTER_COUNT > 1 ? '1 : '0)];
    assign m_index = ob_idx[ob_ptr[FW-1:0] & FW'(FILTER_COUNT > 1 ? '1 : '0)];
    assign m_done  = ob_done[ob_ptr[FW-1:0] & FW'(FILTER_COUNT > 1 ? '1 : '0)];

endmodule

// ----- rtl/conv3x3_maxpool_features_core.sv -----
// Latency: a window-completing pixel passes the front item register, product
// stage and result buffer before its first result is offered; the remaining
// results follow one per cycle as the output accepts. Throughput: one item
// per cycle, but input stalls while a completed window's results drain.
// Reset: synchronous on aresetn; coefficients, line buffers, window, pooling
// maxima and position counters all clear to zero.
module conv3x3_maxpool_features_core #(
    parameter int IMAGE_SIZE   = 11,
    parameter int POOL_OUT     = 3,
    parameter int FILTER_COUNT = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // filter_sel, coef_index[3:0], coef_value[15:0], pixel[15:0], 3 zero bits
    input  logic [39:0] s_tdata,
    // mode
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // feature_value[35:0], feature_index[4:0], 7 zero bits
    output logic [47:0] m_tdata,
    output logic        m_tlast
);

    logic               q_valid, q_ready;
    cmf_pkg::cmf_item_t q_item;
    logic               q_mode, q_f;
    logic [3:0]         q_k;
    logic [15:0]        q_c;
    logic [35:0]        v;
    logic [4:0]         ix;
    logic               load_fire;

    // Load fields ride along in a small register next to the front stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_mode <= 1'b1;
        end else if (q_ready || !q_valid) begin
            q_mode <= s_tuser;
            q_f    <= s_tdata[0];
            q_k    <= s_tdata[4:1];
            q_c    <= s_tdata[20:5];
        end
    end

    assign s_tready  = q_ready || !q_valid;
    assign load_fire = q_valid && q_ready && q_mode == cmf_pkg::MODE_LOAD;

    cmf_front #(.IMAGE_SIZE(IMAGE_SIZE), .POOL_OUT(POOL_OUT)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid && s_tready), .in_mode(s_tuser),
        .in_pixel(s_tdata[36:21]), .out_ready(q_ready),
        .out_valid(q_valid), .out_item(q_item)
    );

    cmf_back #(.POOL_OUT(POOL_OUT), .FILTER_COUNT(FILTER_COUNT)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .load_en(load_fire), .load_filter(q_f), .load_index(q_k), .load_value(q_c),
        .in_valid(q_valid), .in_item(q_item), .in_ready(q_ready),
        .m_valid(m_tvalid), .m_value(v), .m_index(ix), .m_done(m_tlast),
        .m_ready(m_tready)
    );

    assign m_tdata = {7'd0, ix, v};

endmodule
